@@ rtl/dsf_pkg.sv @@
// Package: constants, power-of-ten tables and shared types for the decimal converter.
`timescale 1ns / 1ps
`default_nettype none
package dsf_pkg;

    localparam int SIG_DIGITS_DEF  = 10;
    localparam int ADJUST_BITS_DEF = 12;

    localparam logic [2:0] PH_SIGN  = 3'd0;
    localparam logic [2:0] PH_INT   = 3'd1;
    localparam logic [2:0] PH_FRAC  = 3'd2;
    localparam logic [2:0] PH_ESIGN = 3'd3;
    localparam logic [2:0] PH_EDIG  = 3'd4;

    localparam logic [35:0] TOP36   = 36'o400000000000;
    localparam logic [35:0] BIGGEST = 36'o377777777777;
    localparam int          TOTAL_MIN = -48;
    localparam int          TOTAL_MAX = 38;
    localparam logic [9:0]  EXP_MAX = 10'd1023;

    typedef struct packed {
        logic [33:0] acc;
        logic [16:0] total;
        logic        neg;
    } dsf_job_t;

    function automatic logic [35:0] pow_mant(input logic [6:0] k);
        logic [35:0] r;
        case (k)
            7'd0: r = 36'o566111742473; 7'd1: r = 36'o723534333211;
            7'd2: r = 36'o444231611026; 7'd3: r = 36'o555300153233;
            7'd4: r = 36'o710560206102; 7'd5: r = 36'o435346123651;
            7'd6: r = 36'o544637550624; 7'd7: r = 36'o676007502771;
            7'd8: r = 36'o426604611673; 7'd9: r = 36'o534345754252;
            7'd10: r = 36'o663437347325; 7'd11: r = 36'o420163520505;
            7'd12: r = 36'o524220444626; 7'd13: r = 36'o651264555774;
            7'd14: r = 36'o411660744575; 7'd15: r = 36'o514235135735;
            7'd16: r = 36'o637304365324; 7'd17: r = 36'o403472631304;
            7'd18: r = 36'o504411377565; 7'd19: r = 36'o625513677523;
            7'd20: r = 36'o773036657450; 7'd21: r = 36'o474723215571;
            7'd22: r = 36'o614110061127; 7'd23: r = 36'o757132075355;
            7'd24: r = 36'o465370246324; 7'd25: r = 36'o602666320011;
            7'd26: r = 36'o743444004013; 7'd27: r = 36'o456166402407;
            7'd28: r = 36'o571624103111; 7'd29: r = 36'o730171123733;
            7'd30: r = 36'o447113564351; 7'd31: r = 36'o560736521443;
            7'd32: r = 36'o715126245754; 7'd33: r = 36'o440165747563;
            7'd34: r = 36'o550223341520; 7'd35: r = 36'o702270232044;
            7'd36: r = 36'o431363140226; 7'd37: r = 36'o537657770274;
            7'd38: r = 36'o667633766353; 7'd39: r = 36'o422701372023;
            7'd40: r = 36'o527461670430; 7'd41: r = 36'o655376246536;
            7'd42: r = 36'o414336750132; 7'd43: r = 36'o517426542161;
            7'd44: r = 36'o643334272616; 7'd45: r = 36'o406111564570;
            7'd46: r = 36'o507534121727; 7'd47: r = 36'o631463146314;
            7'd48: r = 36'o400000000000; 7'd49: r = 36'o500000000000;
            7'd50: r = 36'o620000000000; 7'd51: r = 36'o764000000000;
            7'd52: r = 36'o470400000000; 7'd53: r = 36'o606500000000;
            7'd54: r = 36'o750220000000; 7'd55: r = 36'o461132000000;
            7'd56: r = 36'o575360400000; 7'd57: r = 36'o734654500000;
            7'd58: r = 36'o452013710000; 7'd59: r = 36'o564416672000;
            7'd60: r = 36'o721522450400; 7'd61: r = 36'o443023471240;
            7'd62: r = 36'o553630407510; 7'd63: r = 36'o706576511432;
            7'd64: r = 36'o434157115760; 7'd65: r = 36'o543212741354;
            7'd66: r = 36'o674055531647; 7'd67: r = 36'o425434430110;
            7'd68: r = 36'o532743536132; 7'd69: r = 36'o661534465561;
            7'd70: r = 36'o417031701446; 7'd71: r = 36'o522640261760;
            7'd72: r = 36'o647410336354; 7'd73: r = 36'o410545213024;
            7'd74: r = 36'o512676455631; 7'd75: r = 36'o635456171177;
            7'd76: r = 36'o402374713617; 7'd77: r = 36'o503074076563;
            7'd78: r = 36'o623713116320; 7'd79: r = 36'o770675742004;
            7'd80: r = 36'o473426555202; 7'd81: r = 36'o612334310443;
            7'd82: r = 36'o755023372554; 7'd83: r = 36'o464114134543;
            7'd84: r = 36'o601137163674; 7'd85: r = 36'o741367020653;
            7'd86: r = 36'o454732312413; 7'd87: r = 36'o570120775116;
            7'd88: r = 36'o726145174341; 7'd89: r = 36'o445677215615;
            7'd90: r = 36'o557257061160; 7'd91: r = 36'o713132675414;
            7'd92: r = 36'o436770626347; 7'd93: r = 36'o546566774041;
            7'd94: r = 36'o700324573052; 7'd95: r = 36'o430204754732;
            7'd96: r = 36'o536246150120;
            default: r = 36'o400000000000;
        endcase
        return r;
    endfunction

    function automatic logic [8:0] pow_exp(input logic [6:0] k);
        logic [8:0] r;
        case (k)
            7'd0: r = 9'o741; 7'd1: r = 9'o744; 7'd2: r = 9'o750; 7'd3: r = 9'o753;
            7'd4: r = 9'o756; 7'd5: r = 9'o762; 7'd6: r = 9'o765; 7'd7: r = 9'o770;
            7'd8: r = 9'o774; 7'd9: r = 9'o777; 7'd10: r = 9'o002; 7'd11: r = 9'o006;
            7'd12: r = 9'o011; 7'd13: r = 9'o014; 7'd14: r = 9'o020; 7'd15: r = 9'o023;
            7'd16: r = 9'o026; 7'd17: r = 9'o032; 7'd18: r = 9'o035; 7'd19: r = 9'o040;
            7'd20: r = 9'o043; 7'd21: r = 9'o047; 7'd22: r = 9'o052; 7'd23: r = 9'o055;
            7'd24: r = 9'o061; 7'd25: r = 9'o064; 7'd26: r = 9'o067; 7'd27: r = 9'o073;
            7'd28: r = 9'o076; 7'd29: r = 9'o101; 7'd30: r = 9'o105; 7'd31: r = 9'o110;
            7'd32: r = 9'o113; 7'd33: r = 9'o117; 7'd34: r = 9'o122; 7'd35: r = 9'o125;
            7'd36: r = 9'o131; 7'd37: r = 9'o134; 7'd38: r = 9'o137; 7'd39: r = 9'o143;
            7'd40: r = 9'o146; 7'd41: r = 9'o151; 7'd42: r = 9'o155; 7'd43: r = 9'o160;
            7'd44: r = 9'o163; 7'd45: r = 9'o167; 7'd46: r = 9'o172; 7'd47: r = 9'o175;
            7'd48: r = 9'o201; 7'd49: r = 9'o204; 7'd50: r = 9'o207; 7'd51: r = 9'o212;
            7'd52: r = 9'o216; 7'd53: r = 9'o221; 7'd54: r = 9'o224; 7'd55: r = 9'o230;
            7'd56: r = 9'o233; 7'd57: r = 9'o236; 7'd58: r = 9'o242; 7'd59: r = 9'o245;
            7'd60: r = 9'o250; 7'd61: r = 9'o254; 7'd62: r = 9'o257; 7'd63: r = 9'o262;
            7'd64: r = 9'o266; 7'd65: r = 9'o271; 7'd66: r = 9'o274; 7'd67: r = 9'o300;
            7'd68: r = 9'o303; 7'd69: r = 9'o306; 7'd70: r = 9'o312; 7'd71: r = 9'o315;
            7'd72: r = 9'o320; 7'd73: r = 9'o324; 7'd74: r = 9'o327; 7'd75: r = 9'o332;
            7'd76: r = 9'o336; 7'd77: r = 9'o341; 7'd78: r = 9'o344; 7'd79: r = 9'o347;
            7'd80: r = 9'o353; 7'd81: r = 9'o356; 7'd82: r = 9'o361; 7'd83: r = 9'o365;
            7'd84: r = 9'o370; 7'd85: r = 9'o373; 7'd86: r = 9'o377; 7'd87: r = 9'o402;
            7'd88: r = 9'o405; 7'd89: r = 9'o411; 7'd90: r = 9'o414; 7'd91: r = 9'o417;
            7'd92: r = 9'o423; 7'd93: r = 9'o426; 7'd94: r = 9'o431; 7'd95: r = 9'o435;
            7'd96: r = 9'o440;
            default: r = 9'o201;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/decimal_string_to_float_core.sv @@
// Top level: decimal text to 36-bit float, parser plus conversion sequencer.
// A character that does not end the number is taken with no result.
// The closing character: a zero value or an out-of-range total gives the word directly, otherwise
// normalise (up to 35 shifts), four 18x18 multiply steps, at most one more shift, round.
// Throughput: one character per cycle until the closing one; then no beat until the word is taken.
// Reset: rst_n asynchronous, active low, clears parser, sequencer and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none
module decimal_string_to_float_core
    import dsf_pkg::*;
#(
    parameter int SIG_DIGITS  = SIG_DIGITS_DEF,
    parameter int ADJUST_BITS = ADJUST_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  character,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [35:0]      float_word
);

    logic     busy_reg, busy_next;
    logic     ov_reg;
    logic [35:0] w_reg;
    logic     take, fire, done;
    dsf_job_t job;
    logic [35:0] cw;

    assign in_stall  = busy_reg || ov_reg;
    assign take      = in_valid && !in_stall;
    assign busy_next = (busy_reg && !done) || fire;

    dsf_parser #(.SIG_DIGITS(SIG_DIGITS), .ADJUST_BITS(ADJUST_BITS)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .character (character),
        .last      (last),
        .fire      (fire),
        .job       (job)
    );

    dsf_convert u_convert
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fire),
        .job   (job),
        .done  (done),
        .word  (cw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            if (done)
            begin
                ov_reg <= 1'b1;
                w_reg  <= cw;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign float_word = w_reg;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !ov_reg) else $error("word overwritten");
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy_reg) else $error("done while idle");
    a_fire_free: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !busy_reg && !ov_reg) else $error("start while busy");
`endif

endmodule
`default_nettype wire

@@ rtl/dsf_parser.sv @@
// Character parser: grammar phases, digit accumulation and decimal adjust.
`timescale 1ns / 1ps
`default_nettype none
module dsf_parser
    import dsf_pkg::*;
#(
    parameter int SIG_DIGITS  = SIG_DIGITS_DEF,
    parameter int ADJUST_BITS = ADJUST_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       take,
    input  wire logic [7:0] character,
    input  wire logic       last,
    output logic            fire,
    output dsf_job_t        job
);

    localparam logic signed [ADJUST_BITS-1:0] ADJ_MAX = {1'b0, {(ADJUST_BITS-1){1'b1}}};
    localparam logic signed [ADJUST_BITS-1:0] ADJ_MIN = {1'b1, {(ADJUST_BITS-1){1'b0}}};

    logic [2:0]                    phase_reg, phase_next;
    logic                          vneg_reg, vneg_next;
    logic                          eneg_reg, eneg_next;
    logic [33:0]                   acc_reg, acc_next;
    logic [3:0]                    cnt_reg, cnt_next;
    logic signed [ADJUST_BITS-1:0] adj_reg, adj_next;
    logic [9:0]                    expv_reg, expv_next;
    logic                          sent_reg, sent_next;

    logic       dig;
    logic [3:0] d;
    logic       ok;
    logic [2:0] ph;
    logic       adj_up, adj_dn;
    logic [13:0] ev;
    logic signed [16:0] tot;

    assign dig = (character >= 8'h30) && (character <= 8'h39);
    assign d   = character[3:0];

    always_comb
    begin
        phase_next = phase_reg;
        vneg_next  = vneg_reg;
        eneg_next  = eneg_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        expv_next  = expv_reg;
        adj_up     = 1'b0;
        adj_dn     = 1'b0;
        ok         = 1'b0;
        ev         = {4'd0, expv_reg} * 14'd10 + {10'd0, d};
        ph         = phase_reg;
        if (ph == PH_SIGN && character != "-" && character != "+")
        begin
            ph         = PH_INT;
            phase_next = PH_INT;
        end
        case (ph)
            PH_SIGN:
            begin
                ok = 1'b1;
                if (character == "-")
                begin
                    vneg_next = ~vneg_reg;
                end
            end
            PH_INT, PH_FRAC:
            begin
                if (dig)
                begin
                    ok = 1'b1;
                    if (!(d == 4'd0 && cnt_reg == 4'd0) && cnt_reg < 4'(SIG_DIGITS))
                    begin
                        acc_next = acc_reg * 34'd10 + {30'd0, d};
                        cnt_next = cnt_reg + 4'd1;
                        adj_dn   = (ph == PH_FRAC);
                    end
                    else if (ph == PH_INT)
                    begin
                        adj_up = (cnt_reg != 4'd0);
                    end
                    else
                    begin
                        adj_dn = (cnt_reg == 4'd0);
                    end
                end
                else if (character == "." && ph == PH_INT)
                begin
                    ok         = 1'b1;
                    phase_next = PH_FRAC;
                end
                else if (character == "e" || character == "E")
                begin
                    ok         = 1'b1;
                    phase_next = PH_ESIGN;
                end
            end
            PH_ESIGN, PH_EDIG:
            begin
                if (dig)
                begin
                    ok         = 1'b1;
                    phase_next = PH_EDIG;
                    expv_next  = (ev > 14'(EXP_MAX)) ? EXP_MAX : ev[9:0];
                end
                else if (ph == PH_ESIGN && (character == "-" || character == "+"))
                begin
                    ok = 1'b1;
                    if (character == "-")
                    begin
                        eneg_next = ~eneg_reg;
                    end
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        adj_next = adj_reg;
        if (adj_up && adj_reg != ADJ_MAX)
        begin
            adj_next = adj_reg + 1'b1;
        end
        else if (adj_dn && adj_reg != ADJ_MIN)
        begin
            adj_next = adj_reg - 1'b1;
        end
    end

    // the word always uses the post-parse state
    assign tot = 17'(adj_next) + (eneg_next ? -17'(signed'({1'b0, expv_next}))
                                            : 17'(signed'({1'b0, expv_next})));
    assign fire = take && !sent_reg && (!ok || last);
    assign sent_next = sent_reg || (!ok);
    assign job = {acc_next, tot, vneg_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIGN;
            vneg_reg  <= 1'b0;
            eneg_reg  <= 1'b0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
            adj_reg   <= '0;
            expv_reg  <= '0;
            sent_reg  <= 1'b0;
        end
        else if (take)
        begin
            if (last)
            begin
                phase_reg <= PH_SIGN;
                vneg_reg  <= 1'b0;
                eneg_reg  <= 1'b0;
                acc_reg   <= '0;
                cnt_reg   <= '0;
                adj_reg   <= '0;
                expv_reg  <= '0;
                sent_reg  <= 1'b0;
            end
            else if (!sent_reg)
            begin
                phase_reg <= phase_next;
                vneg_reg  <= vneg_next;
                eneg_reg  <= eneg_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
                adj_reg   <= adj_next;
                expv_reg  <= expv_next;
                sent_reg  <= sent_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 4'(SIG_DIGITS)) else $error("digit count overrun");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && last |=> !sent_reg && phase_reg == PH_SIGN) else $error("no clear on last");
    a_sent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg |-> !fire) else $error("second word");
`endif

endmodule
`default_nettype wire

@@ rtl/dsf_convert.sv @@
// Converter: range check, normalise, shared 18x18 multiplies, normalise, round.
`timescale 1ns / 1ps
`default_nettype none
module dsf_convert
    import dsf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire dsf_job_t  job,
    output logic           done,
    output logic [35:0]    word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NRM1 = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_NRM2 = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;

    logic [2:0]  st_reg, st_next;
    logic [35:0] f_reg;
    logic [71:0] p_reg;
    logic [35:0] m_reg;
    logic [6:0]  k_reg;
    logic [1:0]  step_reg;
    logic signed [9:0] sh_reg;
    logic        neg_reg;
    logic [35:0] word_reg;
    logic        done_reg;

    logic [17:0] ma, mb;
    logic [35:0] prod;
    logic [27:0] fr;
    logic [28:0] fr1;
    logic signed [10:0] e;
    logic [35:0] mag;

    // one shared 18x18 multiplier, four partial products in turn
    always_comb
    begin
        case (step_reg)
            2'd0:    begin ma = f_reg[17:0];  mb = m_reg[17:0];  end
            2'd1:    begin ma = f_reg[35:18]; mb = m_reg[17:0];  end
            2'd2:    begin ma = f_reg[17:0];  mb = m_reg[35:18]; end
            default: begin ma = f_reg[35:18]; mb = m_reg[35:18]; end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        fr  = p_reg[71:44];
        fr1 = {1'b0, fr} + {28'd0, fr[0]};
        e   = 11'(signed'(pow_exp(k_reg))) + 11'sd36 - 11'(sh_reg)
              + (fr1[28] ? 11'sd1 : 11'sd0);
        mag = fr1[28] ? {1'b0, e[7:0], fr1[28:2]} : {1'b0, e[7:0], fr1[27:1]};
        st_next = st_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        neg_reg <= job.neg;
                        f_reg   <= {2'd0, job.acc};
                        sh_reg  <= '0;
                        if (job.acc == '0 || $signed(job.total) < TOTAL_MIN)
                        begin
                            word_reg <= '0;
                            done_reg <= 1'b1;
                        end
                        else if ($signed(job.total) > TOTAL_MAX)
                        begin
                            word_reg <= job.neg ? -BIGGEST : BIGGEST;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            k_reg  <= 7'(job.total + 17'sd48);
                            m_reg  <= pow_mant(7'(job.total + 17'sd48));
                            st_reg <= S_NRM1;
                        end
                    end
                end
                S_NRM1:
                begin
                    if (f_reg[35])
                    begin
                        step_reg <= 2'd0;
                        p_reg    <= '0;
                        st_reg   <= S_MUL;
                    end
                    else
                    begin
                        f_reg  <= {f_reg[34:0], 1'b0};
                        sh_reg <= sh_reg + 10'sd1;
                    end
                end
                S_MUL:
                begin
                    case (step_reg)
                        2'd0:    p_reg <= p_reg + {36'd0, prod};
                        2'd1,
                        2'd2:    p_reg <= p_reg + {18'd0, prod, 18'd0};
                        default: p_reg <= p_reg + {prod, 36'd0};
                    endcase
                    step_reg <= step_reg + 2'd1;
                    if (step_reg == 2'd3)
                    begin
                        st_reg <= S_NRM2;
                    end
                end
                S_NRM2:
                begin
                    // bits below the high word are dropped, zeros shift in
                    if (p_reg[71])
                    begin
                        st_reg <= S_RND;
                    end
                    else
                    begin
                        p_reg  <= {p_reg[70:36], 37'd0};
                        sh_reg <= sh_reg + 10'sd1;
                    end
                end
                S_RND:
                begin
                    if (e < 0)
                    begin
                        word_reg <= '0;
                    end
                    else if (e >= 11'sd256)
                    begin
                        word_reg <= neg_reg ? -BIGGEST : BIGGEST;
                    end
                    else
                    begin
                        word_reg <= neg_reg ? -mag : mag;
                    end
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default:
                begin
                    st_reg <= st_next;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign word = word_reg;

`ifndef NO_ASSERTIONS
    a_norm: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_MUL |-> f_reg[35]) else $error("multiplicand not normalised");
    a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_RND |=> done_reg) else $error("round without done");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> st_reg == S_IDLE) else $error("start while busy");
`endif

endmodule
`default_nettype wire
